// ===== hdl/esc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types, constants and helpers for the environment sensor
// compensation pipeline.
// ----------------------------------------------------------------------------
package esc_pkg;

  typedef enum logic [2:0] {
    REG_TEMP    = 3'd0,
    REG_PRESS_A = 3'd1,
    REG_PRESS_B = 3'd2,
    REG_MIXED   = 3'd3,
    REG_HUMID   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
    logic [7:0]  h1;
    logic [15:0] h2;
    logic [7:0]  h3;
    logic [15:0] h4;
    logic [15:0] h5;
    logic [7:0]  h6;
  } cal_t;

  localparam int LAT_TEMP   = 3;
  localparam int LAT_HUM    = 7;
  localparam int LAT_PFRONT = 6;
  localparam int DIV_BITS   = 64;
  localparam int LAT_DIV    = DIV_BITS + 1;
  localparam int LAT_PBACK  = 5;
  localparam int LAT_TOTAL  = LAT_TEMP + LAT_PFRONT + LAT_DIV + LAT_PBACK;
  localparam int REM_W      = 32;

  localparam logic [31:0] TEMP_OFS_P   = 32'd128000;
  localparam logic [31:0] HUM_TEMP_OFS = 32'd76800;
  localparam logic [31:0] HUM_ROUND_A  = 32'd16384;
  localparam logic [31:0] HUM_OFS_B    = 32'd2097152;
  localparam logic [31:0] HUM_ROUND_B  = 32'd8192;
  localparam logic [31:0] HUM_OFS_C    = 32'd32768;
  localparam logic [31:0] HUM_MAX      = 32'd419430400;
  localparam logic [63:0] PRESS_FULL   = 64'd1048576;
  localparam logic [63:0] PRESS_SCALE  = 64'd3125;
  localparam logic [63:0] PRESS_BIAS   = 64'h0000_8000_0000_0000;

  function automatic logic [31:0] sx16_32(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [63:0] sx16_64(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

endpackage
`default_nettype wire

// ===== hdl/esc_temp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// esc_temp
// Three-stage fine temperature datapath in 32-bit wrapping arithmetic.
// ----------------------------------------------------------------------------
module esc_temp import esc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire cal_t        cal,
  input  wire logic [19:0] raw_temperature,
  input  wire logic [19:0] raw_pressure,
  input  wire logic [15:0] raw_humidity,
  output logic      [31:0] fine,
  output logic      [19:0] press_d,
  output logic      [15:0] humid_d
);

  logic [31:0] at32;
  logic [31:0] t1x;
  logic [31:0] diff_a;
  logic [31:0] diff_d;
  logic [31:0] dd_sh;
  logic [31:0] s1_a;
  logic [31:0] s1_dd;
  logic [31:0] s2_a;
  logic [31:0] s2_b;
  logic [19:0] p_s1;
  logic [19:0] p_s2;
  logic [15:0] h_s1;
  logic [15:0] h_s2;

  assign at32   = {12'b0, raw_temperature};
  assign t1x    = {16'b0, cal.t1};
  assign diff_a = (at32 >> 3) - (t1x << 1);
  assign diff_d = (at32 >> 4) - t1x;
  assign dd_sh  = 32'($signed(s1_dd) >>> 12);

  always_ff @(posedge clk) begin
    if (en) begin
      s1_a    <= diff_a * sx16_32(cal.t2);
      s1_dd   <= diff_d * diff_d;
      p_s1    <= raw_pressure;
      h_s1    <= raw_humidity;
      s2_a    <= 32'($signed(s1_a) >>> 11);
      s2_b    <= dd_sh * sx16_32(cal.t3);
      p_s2    <= p_s1;
      h_s2    <= h_s1;
      fine    <= s2_a + 32'($signed(s2_b) >>> 14);
      press_d <= p_s2;
      humid_d <= h_s2;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/esc_humid.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// esc_humid
// Seven-stage humidity datapath with clamp; also forms the centidegree
// temperature and carries the fine temperature alongside.
// ----------------------------------------------------------------------------
module esc_humid import esc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire cal_t        cal,
  input  wire logic [31:0] fine,
  input  wire logic [15:0] raw_humidity,
  output logic      [31:0] fine_o,
  output logic      [23:0] tc_o,
  output logic      [16:0] hum_o
);

  logic [31:0] x;
  logic [31:0] ha_c;
  logic [31:0] tc_c;
  logic [31:0] b_c;
  logic [31:0] b2_c;
  logic [31:0] e_c;
  logic [31:0] w_c;
  logic [31:0] clamp_c;
  logic [31:0] d_c;

  logic [31:0] h1_ha, h1_xh6, h1_xh3;
  logic [31:0] h2_a, h2_b;
  logic [31:0] h3_a, h3_b2;
  logic [31:0] h4_v;
  logic [31:0] h5_v, h5_dd;
  logic [31:0] h6_v, h6_e;
  logic [31:0] fine_d [LAT_HUM];
  logic [23:0] tc_d   [LAT_HUM];

  assign x    = fine - HUM_TEMP_OFS;
  assign ha_c = ({16'b0, raw_humidity} << 14) - (sx16_32(cal.h4) << 20)
              - (sx16_32(cal.h5) * x) + HUM_ROUND_A;
  assign tc_c = 32'($signed((fine << 2) + fine + 32'd128) >>> 8);
  assign b_c  = 32'($signed(h1_xh6) >>> 10) * (32'($signed(h1_xh3) >>> 11) + HUM_OFS_C);
  assign b2_c = (32'($signed(h2_b) >>> 10) + HUM_OFS_B) * sx16_32(cal.h2) + HUM_ROUND_B;
  assign d_c  = 32'($signed(h4_v) >>> 15);
  assign e_c  = 32'($signed(h5_dd) >>> 7) * {24'b0, cal.h1};
  assign w_c  = h6_v - 32'($signed(h6_e) >>> 4);

  always_comb begin
    clamp_c = w_c;
    if (w_c[31]) begin
      clamp_c = '0;
    end else if (w_c > HUM_MAX) begin
      clamp_c = HUM_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h1_ha     <= ha_c;
      h1_xh6    <= x * {{24{cal.h6[7]}}, cal.h6};
      h1_xh3    <= x * {24'b0, cal.h3};
      fine_d[0] <= fine;
      tc_d[0]   <= tc_c[23:0];
      h2_a      <= 32'($signed(h1_ha) >>> 15);
      h2_b      <= b_c;
      h3_a      <= h2_a;
      h3_b2     <= b2_c;
      h4_v      <= h3_a * 32'($signed(h3_b2) >>> 14);
      h5_v      <= h4_v;
      h5_dd     <= d_c * d_c;
      h6_v      <= h5_v;
      h6_e      <= e_c;
      hum_o     <= clamp_c[28:12];
      for (int k = 1; k < LAT_HUM; k++) begin
        fine_d[k] <= fine_d[k-1];
        tc_d[k]   <= tc_d[k-1];
      end
    end
  end

  assign fine_o = fine_d[LAT_HUM-1];
  assign tc_o   = tc_d[LAT_HUM-1];

endmodule
`default_nettype wire

// ===== hdl/esc_pfront.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// esc_pfront
// Six-stage pressure front end: forms the 64-bit dividend and divisor.
// ----------------------------------------------------------------------------
module esc_pfront import esc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire cal_t        cal,
  input  wire logic [31:0] fine,
  input  wire logic [19:0] raw_pressure,
  output logic      [63:0] num,
  output logic      [63:0] den
);

  logic signed [32:0] v1s;
  logic signed [65:0] vv_f;
  logic signed [48:0] v1p5_f, v1p2_f;
  logic signed [79:0] v2a_f, vv3_f;
  logic        [79:0] sp1_f;
  logic        [63:0] v2_c, v1b_c, num_c;

  logic [63:0] s4_vv;
  logic [48:0] s4_v1p5, s4_v1p2;
  logic [19:0] s4_ap, s5_ap, s6_ap, s7_ap;
  logic [63:0] s5_v2a, s5_vv3;
  logic [48:0] s5_v1p5, s5_v1p2;
  logic [63:0] s6_v2, s6_s;
  logic [63:0] s7_v2, s7_sp1;
  logic [63:0] s8_num, s8_den;

  assign v1s    = $signed({fine[31], fine}) - $signed({1'b0, TEMP_OFS_P});
  assign vv_f   = v1s * v1s;
  assign v1p5_f = v1s * $signed(cal.p5);
  assign v1p2_f = v1s * $signed(cal.p2);
  assign v2a_f  = $signed(s4_vv) * $signed(cal.p6);
  assign vv3_f  = $signed(s4_vv) * $signed(cal.p3);
  assign v2_c   = s5_v2a + ({{15{s5_v1p5[48]}}, s5_v1p5} << 17) + (sx16_64(cal.p4) << 35);
  assign v1b_c  = 64'($signed(s5_vv3) >>> 8) + ({{15{s5_v1p2[48]}}, s5_v1p2} << 12);
  assign sp1_f  = {16'b0, s6_s} * {64'b0, cal.p1};
  assign num_c  = ((PRESS_FULL - {44'b0, s7_ap}) << 31) - s7_v2;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_vv   <= vv_f[63:0];
      s4_v1p5 <= v1p5_f;
      s4_v1p2 <= v1p2_f;
      s4_ap   <= raw_pressure;
      s5_v2a  <= v2a_f[63:0];
      s5_vv3  <= vv3_f[63:0];
      s5_v1p5 <= s4_v1p5;
      s5_v1p2 <= s4_v1p2;
      s5_ap   <= s4_ap;
      s6_v2   <= v2_c;
      s6_s    <= PRESS_BIAS + v1b_c;
      s6_ap   <= s5_ap;
      s7_v2   <= s6_v2;
      s7_sp1  <= sp1_f[63:0];
      s7_ap   <= s6_ap;
      s8_num  <= num_c;
      s8_den  <= 64'($signed(s7_sp1) >>> 33);
      num     <= s8_num * PRESS_SCALE;
      den     <= s8_den;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/esc_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// esc_div
// Pipelined signed divider: one sign stage, then one quotient bit per stage.
// The divisor magnitude always fits in 31 bits.
// ----------------------------------------------------------------------------
module esc_div import esc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [63:0] num,
  input  wire logic [63:0] den,
  output logic      [63:0] quot,
  output logic             neg,
  output logic             zero_div
);

  logic [63:0]      nabs, dabs;
  logic [63:0]      nq [DIV_BITS+1];
  logic [REM_W-1:0] rm [DIV_BITS+1];
  logic [REM_W-1:0] dv [DIV_BITS+1];
  logic             ng [DIV_BITS+1];
  logic             iv [DIV_BITS+1];
  logic [REM_W-1:0] trial [DIV_BITS];
  logic             ge    [DIV_BITS];

  assign nabs = num[63] ? 64'd0 - num : num;
  assign dabs = den[63] ? 64'd0 - den : den;

  for (genvar k = 0; k < DIV_BITS; k++) begin : g_bit
    assign trial[k] = {rm[k][REM_W-2:0], nq[k][63]};
    assign ge[k]    = trial[k] >= dv[k];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nq[0] <= nabs;
      rm[0] <= '0;
      dv[0] <= dabs[REM_W-1:0];
      ng[0] <= num[63] ^ den[63];
      iv[0] <= den == 64'd0;
      for (int k = 0; k < DIV_BITS; k++) begin
        nq[k+1] <= {nq[k][62:0], ge[k]};
        rm[k+1] <= ge[k] ? trial[k] - dv[k] : trial[k];
        dv[k+1] <= dv[k];
        ng[k+1] <= ng[k];
        iv[k+1] <= iv[k];
      end
    end
  end

  assign quot     = nq[DIV_BITS];
  assign neg      = ng[DIV_BITS];
  assign zero_div = iv[DIV_BITS];

endmodule
`default_nettype wire

// ===== hdl/esc_pback.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// esc_pback
// Five-stage pressure back end: sign fix, correction terms and final
// division by 256 toward zero.
// ----------------------------------------------------------------------------
module esc_pback import esc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire cal_t        cal,
  input  wire logic [63:0] quot,
  input  wire logic        neg,
  input  wire logic        zero_div,
  output logic      [31:0] press,
  output logic             invalid
);

  logic [63:0]        pv_c, prod_c, p2_c, pd_c;
  logic signed [79:0] m_f, pr8_f;

  logic [63:0] q1_p;
  logic        q1_iv;
  logic [63:0] q2_p, q2_pv, q2_m, q2_pr8;
  logic        q2_iv;
  logic [63:0] q3_p, q3_pr8, q3_ll;
  logic [31:0] q3_c1, q3_c2;
  logic        q3_iv;
  logic [63:0] q4_sum;
  logic        q4_iv;

  assign pv_c   = 64'($signed(q1_p) >>> 13);
  assign m_f    = $signed(cal.p9) * $signed(pv_c);
  assign pr8_f  = $signed(cal.p8) * $signed(q1_p);
  assign prod_c = q3_ll + {q3_c1 + q3_c2, 32'b0};
  assign p2_c   = 64'($signed(q4_sum) >>> 8) + (sx16_64(cal.p7) << 4);
  assign pd_c   = p2_c[63] ? 64'($signed(p2_c + 64'd255) >>> 8) : (p2_c >> 8);

  always_ff @(posedge clk) begin
    if (en) begin
      q1_p    <= neg ? 64'd0 - quot : quot;
      q1_iv   <= zero_div;
      q2_p    <= q1_p;
      q2_pv   <= pv_c;
      q2_m    <= m_f[63:0];
      q2_pr8  <= pr8_f[63:0];
      q2_iv   <= q1_iv;
      q3_p    <= q2_p;
      q3_pr8  <= q2_pr8;
      q3_ll   <= 64'(q2_m[31:0]) * 64'(q2_pv[31:0]);
      q3_c1   <= q2_m[31:0] * q2_pv[63:32];
      q3_c2   <= q2_m[63:32] * q2_pv[31:0];
      q3_iv   <= q2_iv;
      q4_sum  <= q3_p + 64'($signed(prod_c) >>> 25) + 64'($signed(q3_pr8) >>> 19);
      q4_iv   <= q3_iv;
      press   <= q4_iv ? 32'd0 : pd_c[31:0];
      invalid <= q4_iv;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/environment_sensor_compensation_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// environment_sensor_compensation_unit
// Compensates raw temperature, pressure and humidity readings using the
// factory calibration words held in five configuration registers.
// ----------------------------------------------------------------------------
// Pipeline depth is set mostly by the one-bit-per-stage 64-bit
// pressure divider (65 of those stages).
// Throughput: one request per cycle; the whole pipeline holds while a
// finished result is stalled at the output.
// Reset clears the calibration registers and all pipeline valid bits.
module environment_sensor_compensation_unit import esc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [19:0] raw_temperature,
  input  wire logic [19:0] raw_pressure,
  input  wire logic [15:0] raw_humidity,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [31:0] fine_temperature,
  output logic      [23:0] temperature_centi,
  output logic      [31:0] pressure_pa,
  output logic      [16:0] humidity_q10,
  output logic             pressure_invalid
);

  localparam int SIDE_LEN = LAT_TOTAL - LAT_TEMP - LAT_HUM;

  logic [47:0] reg_temp;
  logic [63:0] reg_press_a;
  logic [63:0] reg_press_b;
  logic [47:0] reg_mixed;
  logic [39:0] reg_humid;
  cal_t        cal;

  logic [LAT_TOTAL-1:0] vld;
  logic                 en;

  logic [31:0] fine;
  logic [19:0] press_d;
  logic [15:0] humid_d;
  logic [31:0] fine_h;
  logic [23:0] tc_h;
  logic [16:0] hum_h;
  logic [63:0] num, den, quot;
  logic        neg, zero_div;

  logic [31:0] side_fine [SIDE_LEN];
  logic [23:0] side_tc   [SIDE_LEN];
  logic [16:0] side_hum  [SIDE_LEN];

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_temp    <= '0;
      reg_press_a <= '0;
      reg_press_b <= '0;
      reg_mixed   <= '0;
      reg_humid   <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_TEMP:    reg_temp    <= cfg_data[47:0];
        REG_PRESS_A: reg_press_a <= cfg_data;
        REG_PRESS_B: reg_press_b <= cfg_data;
        REG_MIXED:   reg_mixed   <= cfg_data[47:0];
        REG_HUMID:   reg_humid   <= cfg_data[39:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cal.t1 = reg_temp[15:0];
    cal.t2 = reg_temp[31:16];
    cal.t3 = reg_temp[47:32];
    cal.p1 = reg_press_a[15:0];
    cal.p2 = reg_press_a[31:16];
    cal.p3 = reg_press_a[47:32];
    cal.p4 = reg_press_a[63:48];
    cal.p5 = reg_press_b[15:0];
    cal.p6 = reg_press_b[31:16];
    cal.p7 = reg_press_b[47:32];
    cal.p8 = reg_press_b[63:48];
    cal.p9 = reg_mixed[15:0];
    cal.h1 = reg_mixed[23:16];
    cal.h2 = reg_mixed[39:24];
    cal.h3 = reg_mixed[47:40];
    cal.h4 = reg_humid[15:0];
    cal.h5 = reg_humid[31:16];
    cal.h6 = reg_humid[39:32];
  end

  assign en       = !(vld[LAT_TOTAL-1] && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT_TOTAL-2:0], in_valid};
    end
  end

  esc_temp u_temp (
    .clk             (clk),
    .en              (en),
    .cal             (cal),
    .raw_temperature (raw_temperature),
    .raw_pressure    (raw_pressure),
    .raw_humidity    (raw_humidity),
    .fine            (fine),
    .press_d         (press_d),
    .humid_d         (humid_d)
  );

  esc_humid u_humid (
    .clk          (clk),
    .en           (en),
    .cal          (cal),
    .fine         (fine),
    .raw_humidity (humid_d),
    .fine_o       (fine_h),
    .tc_o         (tc_h),
    .hum_o        (hum_h)
  );

  esc_pfront u_pfront (
    .clk          (clk),
    .en           (en),
    .cal          (cal),
    .fine         (fine),
    .raw_pressure (press_d),
    .num          (num),
    .den          (den)
  );

  esc_div u_div (
    .clk      (clk),
    .en       (en),
    .num      (num),
    .den      (den),
    .quot     (quot),
    .neg      (neg),
    .zero_div (zero_div)
  );

  esc_pback u_pback (
    .clk      (clk),
    .en       (en),
    .cal      (cal),
    .quot     (quot),
    .neg      (neg),
    .zero_div (zero_div),
    .press    (pressure_pa),
    .invalid  (pressure_invalid)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      side_fine[0] <= fine_h;
      side_tc[0]   <= tc_h;
      side_hum[0]  <= hum_h;
      for (int k = 1; k < SIDE_LEN; k++) begin
        side_fine[k] <= side_fine[k-1];
        side_tc[k]   <= side_tc[k-1];
        side_hum[k]  <= side_hum[k-1];
      end
    end
  end

  assign out_valid         = vld[LAT_TOTAL-1];
  assign fine_temperature  = side_fine[SIDE_LEN-1];
  assign temperature_centi = side_tc[SIDE_LEN-1];
  assign humidity_q10      = side_hum[SIDE_LEN-1];

  a_stall_only_on_blocked_output: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow a blocked output");

  a_invalid_forces_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && pressure_invalid) |-> (pressure_pa == 32'd0))
    else $error("pressure not zero on zero divisor");

  a_humidity_clamped: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (humidity_q10 <= 17'd102400))
    else $error("humidity result beyond clamp");

  a_pipe_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(vld))
    else $error("pipeline moved while output blocked");

endmodule
`default_nettype wire
